// ----- design/escfr_pkg.sv -----
// ----------------------------------------------------------------------------
// escfr_pkg
// Shared types and codes for the escaped frame receiver.
// ----------------------------------------------------------------------------
package escfr_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_START_CODE        = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ESCAPE_CODE       = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ESCAPED_START     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ESCAPED_ESCAPE    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CHECKSUM_SUBST    = 3'd4;

  // frame verdict codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD_LEN = 3'd1,
    ST_BAD_CPL = 3'd2,
    ST_INV_ESC = 3'd3,
    ST_BAD_SUM = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] escape_code;
    logic [7:0] escaped_start_code;
    logic [7:0] escaped_escape_code;
    logic [7:0] checksum_substitute_code;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       has_data;
    logic [6:0] byte_index;
    logic       frame_end;
    status_e    status;
  } result_t;

endpackage

// ----- design/escaped_frame_receiver.sv -----
// timing: an accepted beat is held in the input register, decoded from it, and
//   its result is registered in the result buffer before it can be taken
// throughput: one byte per cycle while the output is not stalled; the two-entry
//   result buffer lets input continue one beat past an output stall, then tready drops
// reset: rst_ni asynchronous active low; hunting for start, buffers empty,
//   configuration back to its default codes
// ----------------------------------------------------------------------------
// escaped_frame_receiver
// Byte-stuffed frame deframer with XOR checksum check, stream in and out.
// ----------------------------------------------------------------------------
module escaped_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // raw link bytes
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic        s_axis_tuser_i,   // [0] op (1 = restart)
  // decoded results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] data_byte, [14:8] byte_index,
                                        // [17:15] status, [23:18] zero
  output logic        m_axis_tuser_o,   // [0] has_data
  output logic        m_axis_tlast_o    // frame_end
);
  import escfr_pkg::*;

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_code               <= 8'd126;
      cfg_q.escape_code              <= 8'd125;
      cfg_q.escaped_start_code       <= 8'd94;
      cfg_q.escaped_escape_code      <= 8'd93;
      cfg_q.checksum_substitute_code <= 8'd124;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_START_CODE:     cfg_q.start_code               <= cfg_data_i;
        CFG_ESCAPE_CODE:    cfg_q.escape_code              <= cfg_data_i;
        CFG_ESCAPED_START:  cfg_q.escaped_start_code       <= cfg_data_i;
        CFG_ESCAPED_ESCAPE: cfg_q.escaped_escape_code      <= cfg_data_i;
        CFG_CHECKSUM_SUBST: cfg_q.checksum_substitute_code <= cfg_data_i;
        default: ;  // writes past the list are dropped
      endcase
    end
  end

  // input register
  logic       in_valid_q;
  logic       in_op_q;
  logic [7:0] in_byte_q;
  logic       proc_fire;
  logic       skid_valid_q;

  // the decode stage may run whenever the result buffer has a free slot
  assign proc_fire       = in_valid_q && !skid_valid_q;
  assign s_axis_tready_o = !in_valid_q || proc_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (proc_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_op_q   <= s_axis_tuser_i;
      in_byte_q <= s_axis_tdata_i;
    end
  end

  // deframing state machine
  result_t res;

  escfr_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (proc_fire),
    .op_i   (in_op_q),
    .byte_i (in_byte_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // two-entry result buffer: output register plus skid
  logic    out_valid_q;
  result_t out_q;
  result_t skid_q;
  logic    push;
  logic    pop;

  assign push = proc_fire && res.valid;
  assign pop  = out_valid_q && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_q.status, out_q.byte_index, out_q.data_byte};
  assign m_axis_tuser_o  = out_q.has_data;
  assign m_axis_tlast_o  = out_q.frame_end;

`ifndef ASSERT_OFF
  // the skid entry only fills behind a stalled output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a beat while output register is empty");

  // every delivered beat carries data or a frame end
  a_beat_content: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o || m_axis_tlast_o)
    else $error("empty result beat");

  // a fault code only travels with a frame end
  a_status_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> out_q.status == ST_OK)
    else $error("status set without frame end");

  // no result is pushed while both buffer entries are occupied
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !pop |-> !push)
    else $error("result buffer overflow");
`endif

endmodule

// ----- design/escfr_core.sv -----
// ----------------------------------------------------------------------------
// escfr_core
// Deframing state machine: one raw byte per fire, at most one result.
// ----------------------------------------------------------------------------
module escfr_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic                op_i,
  input  logic [7:0]          byte_i,
  input  escfr_pkg::cfg_t     cfg_i,
  output escfr_pkg::result_t  res_o
);
  import escfr_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_LENGTHX = 3'd2,
    PH_CKSUM   = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_ERROR   = 3'd5
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [6:0] remaining_q, remaining_d;
  logic [7:0] xor_sum_q, xor_sum_d;
  logic [7:0] check_value_q, check_value_d;
  logic       prev_esc_q, prev_esc_d;
  logic [6:0] out_count_q, out_count_d;

  function automatic status_e verdict(logic [7:0] xs, logic [7:0] cv, cfg_t cfg);
    logic [7:0] s_chk;
    logic [7:0] s_start;
    logic [7:0] s_esc;
    s_chk   = 8'(xs + cv);
    s_start = 8'(xs + cfg.start_code);
    s_esc   = 8'(xs + cfg.escape_code);
    if (s_chk == 8'h00) begin
      return ST_OK;
    end
    if (cv == cfg.checksum_substitute_code && (s_start == 8'h00 || s_esc == 8'h00)) begin
      return ST_OK;
    end
    return ST_BAD_SUM;
  endfunction

  always_comb begin
    phase_d       = phase_q;
    remaining_d   = remaining_q;
    xor_sum_d     = xor_sum_q;
    check_value_d = check_value_q;
    prev_esc_d    = prev_esc_q;
    out_count_d   = out_count_q;
    res_o         = '0;

    if (fire_i) begin
      if (op_i) begin
        // restart clears everything but configuration
        phase_d       = PH_HUNT;
        remaining_d   = '0;
        xor_sum_d     = '0;
        check_value_d = '0;
        prev_esc_d    = 1'b0;
        out_count_d   = '0;
      end else begin
        unique case (phase_q)
          PH_HUNT: begin
            if (byte_i == cfg_i.start_code) phase_d = PH_LENGTH;
          end
          PH_LENGTH: begin
            if (byte_i == cfg_i.start_code || byte_i == 8'h00) begin
              phase_d         = PH_ERROR;
              res_o.frame_end = 1'b1;
              res_o.status    = ST_BAD_LEN;
            end else begin
              xor_sum_d   = byte_i;
              remaining_d = byte_i[6:0];
              phase_d     = PH_LENGTHX;
            end
          end
          PH_LENGTHX: begin
            if (byte_i == cfg_i.start_code || (~byte_i & 8'h7f) != xor_sum_q) begin
              phase_d         = PH_ERROR;
              res_o.frame_end = 1'b1;
              res_o.status    = ST_BAD_CPL;
            end else begin
              phase_d = PH_CKSUM;
            end
            xor_sum_d = xor_sum_q ^ byte_i;
          end
          PH_CKSUM: begin
            check_value_d = byte_i;
            remaining_d   = remaining_q - 7'd1;
            out_count_d   = '0;
            if (remaining_d == 7'd0) begin
              res_o.frame_end = 1'b1;
              res_o.status    = verdict(xor_sum_q, byte_i, cfg_i);
              phase_d         = PH_HUNT;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            xor_sum_d   = xor_sum_q ^ byte_i;
            remaining_d = remaining_q - 7'd1;
            if (prev_esc_q) begin
              if (byte_i == cfg_i.escaped_start_code) begin
                res_o.has_data  = 1'b1;
                res_o.data_byte = cfg_i.start_code;
              end else if (byte_i == cfg_i.escaped_escape_code) begin
                res_o.has_data  = 1'b1;
                res_o.data_byte = cfg_i.escape_code;
              end else begin
                phase_d         = PH_ERROR;
                res_o.frame_end = 1'b1;
                res_o.status    = ST_INV_ESC;
              end
            end else if (byte_i != cfg_i.escape_code) begin
              res_o.has_data  = 1'b1;
              res_o.data_byte = byte_i;
            end
            if (res_o.has_data) begin
              res_o.byte_index = out_count_q;
              out_count_d      = out_count_q + 7'd1;
            end
            // invalid escape wins over the end-of-frame verdict
            if (phase_d == PH_PAYLOAD && remaining_d == 7'd0) begin
              res_o.frame_end = 1'b1;
              res_o.status    = verdict(xor_sum_d, check_value_q, cfg_i);
              phase_d         = PH_HUNT;
            end
          end
          PH_ERROR: begin
          end
          default: begin
          end
        endcase
        prev_esc_d = (byte_i == cfg_i.escape_code);
      end
    end
    res_o.valid = res_o.has_data | res_o.frame_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_HUNT;
      remaining_q   <= '0;
      xor_sum_q     <= '0;
      check_value_q <= '0;
      prev_esc_q    <= 1'b0;
      out_count_q   <= '0;
    end else begin
      phase_q       <= phase_d;
      remaining_q   <= remaining_d;
      xor_sum_q     <= xor_sum_d;
      check_value_q <= check_value_d;
      prev_esc_q    <= prev_esc_d;
      out_count_q   <= out_count_d;
    end
  end

`ifndef ASSERT_OFF
  // the error phase swallows bytes silently
  a_error_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && phase_q == PH_ERROR |-> !res_o.valid)
    else $error("result produced in error phase");

  // a restart never yields a result and lands in hunt
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && op_i |-> !res_o.valid ##1 phase_q == PH_HUNT)
    else $error("restart not handled");

  // entering the error phase always reports a frame end with a fault
  a_error_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_ERROR && phase_d == PH_ERROR |-> res_o.frame_end && res_o.status != ST_OK)
    else $error("silent entry into error phase");
`endif

endmodule
